@@ sv/lfsm_pkg.sv @@
// Shared types, codes and defaults for the latest-frame slot manager.
`timescale 1ns / 1ps
`default_nettype none
package lfsm_pkg;

	localparam int SLOT_COUNT_DEF = 3;
	localparam int SEQ_BITS_DEF   = 32;

	localparam int CMD_W     = 3;
	localparam int IDX_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int CNT_W     = 32;
	localparam int FAIL_W    = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 6;

	localparam logic [CMD_W-1:0] CMD_ACQUIRE     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_COMMIT_OK   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_COMMIT_FAIL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TAKE        = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RELEASE     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR_STATS = 3'd5;

	localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STS_DISABLED = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NO_SLOT  = 2'd2;
	localparam logic [STATUS_W-1:0] STS_WRONG    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_THRESHOLD = 2'd1;

	localparam logic [FAIL_W-1:0] FAIL_THRESHOLD_RST = 6'd30;
	localparam logic [FAIL_W-1:0] FAIL_MAX           = 6'd63;

	typedef enum logic [1:0] {
		SLOT_FREE  = 2'd0,
		SLOT_READY = 2'd1,
		SLOT_INUSE = 2'd2
	} slot_state_t;

	// write request into the slot store
	typedef struct packed {
		logic        en;
		logic        seq_en;
		slot_state_t state;
	} slot_wr_t;

endpackage
`default_nettype wire

@@ sv/latest_frame_slot_manager.sv @@
// Latest-frame slot manager: sequencer, shared seq compare unit and counters.
// Usage:
//   Command channel (cmd_valid/cmd_stall) carries one word: command and
//   slot_index. Response channel (rsp_valid/rsp_stall) returns one word per
//   command: status, granted slot, frame sequence, drop flag, lockout and the
//   four frame counters. Registers enable and fail_threshold are written over
//   cfg_we/cfg_index/cfg_data; the user must do so only while no command is in
//   flight, as the block itself does not enforce this. A command is taken only
//   while the sequencer is idle; cmd_stall stays high through its work, so the
//   next command can be accepted in the same cycle the response goes valid.
//   Acquire and take scan the slots, one slot a cycle through the single
//   sequence comparator, then apply; commit_ok/fail and release read the
//   store, then apply; clear_stats and other codes go straight to apply.
//   A new command may be accepted while the previous response still waits;
//   its state update is held until the response register is free, so a
//   stalled response word stays intact.
//   Reset clears all slots to free, sequence and counters to zero, lockout
//   off, enable off and fail_threshold to 30.
`timescale 1ns / 1ps
`default_nettype none
module latest_frame_slot_manager #(
	parameter int SLOT_COUNT = lfsm_pkg::SLOT_COUNT_DEF,
	parameter int SEQ_BITS   = lfsm_pkg::SEQ_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cmd_valid,
	output logic                                    cmd_stall,
	input  wire logic [lfsm_pkg::CMD_W-1:0]         command,
	input  wire logic [lfsm_pkg::IDX_W-1:0]         slot_index,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	output logic      [lfsm_pkg::STATUS_W-1:0]      status,
	output logic      [lfsm_pkg::IDX_W-1:0]         granted_slot,
	output logic      [lfsm_pkg::CNT_W-1:0]         frame_seq,
	output logic                                    dropped_now,
	output logic                                    locked_out,
	output logic      [lfsm_pkg::CNT_W-1:0]         produced_period,
	output logic      [lfsm_pkg::CNT_W-1:0]         produced_lifetime,
	output logic      [lfsm_pkg::CNT_W-1:0]         dropped_period,
	output logic      [lfsm_pkg::CNT_W-1:0]         dropped_lifetime,
	input  wire logic                               cfg_we,
	input  wire logic [lfsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lfsm_pkg::CFG_W-1:0]         cfg_data
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_LOOK,
		ST_EXEC
	} fsm_t;

	fsm_t state_q;

	logic                              enable_q;
	logic [lfsm_pkg::FAIL_W-1:0]       fail_threshold_q;
	logic [lfsm_pkg::CMD_W-1:0]        cmd_q;
	logic [lfsm_pkg::IDX_W-1:0]        slot_index_q;
	logic [IW-1:0]                     scan_q;
	logic                              cmp_vld_s1;
	logic [IW-1:0]                     cmp_idx_s1;
	logic                              free_found_q;
	logic [IW-1:0]                     free_idx_q;
	logic                              pick_found_q;
	logic [IW-1:0]                     pick_idx_q;
	logic [SEQ_BITS-1:0]               pick_seq_q;
	logic [SEQ_BITS-1:0]               seq_counter_q;
	logic [lfsm_pkg::FAIL_W-1:0]       fail_count_q;
	logic                              lockout_q;
	logic [lfsm_pkg::CNT_W-1:0]        prod_period_q;
	logic [lfsm_pkg::CNT_W-1:0]        prod_total_q;
	logic [lfsm_pkg::CNT_W-1:0]        drop_period_q;
	logic [lfsm_pkg::CNT_W-1:0]        drop_total_q;
	logic                              rsp_valid_q;
	logic [lfsm_pkg::STATUS_W-1:0]     status_q;
	logic [IW-1:0]                     granted_q;
	logic [lfsm_pkg::CNT_W-1:0]        fseq_q;
	logic                              dropped_q;

	logic                              cmd_accept;
	logic                              exec_go;
	logic                              idx_ok;
	logic [IW-1:0]                     look_addr;
	logic [IW-1:0]                     rd_addr;
	lfsm_pkg::slot_state_t             rd_state;
	logic [SEQ_BITS-1:0]               rd_seq;
	lfsm_pkg::slot_wr_t                wr_ctl;
	logic [IW-1:0]                     wr_addr;
	logic [SEQ_BITS-1:0]               seq_next;
	logic [SEQ_BITS-1:0]               cmp_a;
	logic [SEQ_BITS-1:0]               cmp_b;
	logic                              cmp_less;
	logic [lfsm_pkg::FAIL_W-1:0]       fail_next;

	logic [lfsm_pkg::STATUS_W-1:0]     ex_status;
	logic [IW-1:0]                     ex_granted;
	logic [SEQ_BITS-1:0]               ex_fseq;
	logic                              ex_dropped;
	logic                              ex_commit;
	logic                              ex_fail;
	logic                              ex_clear;

	assign cmd_stall  = (state_q != ST_IDLE);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign exec_go    = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);

	assign idx_ok    = ({3'b000, slot_index_q} < 5'(SLOT_COUNT));
	assign look_addr = idx_ok ? IW'(slot_index_q) : '0;
	assign rd_addr   = (state_q == ST_SCAN) ? scan_q : look_addr;
	assign seq_next  = seq_counter_q + 1'b1;
	assign fail_next = (fail_count_q == lfsm_pkg::FAIL_MAX) ? fail_count_q
	                                                        : fail_count_q + 1'b1;

	// shared compare: take looks for the newest, acquire for the oldest
	assign cmp_a    = (cmd_q == lfsm_pkg::CMD_TAKE) ? pick_seq_q : rd_seq;
	assign cmp_b    = (cmd_q == lfsm_pkg::CMD_TAKE) ? rd_seq : pick_seq_q;
	assign cmp_less = (cmp_a < cmp_b);

	lfsm_slot_store #(
		.SLOT_COUNT(SLOT_COUNT),
		.SEQ_BITS  (SEQ_BITS),
		.IW        (IW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_state(rd_state),
		.rd_seq  (rd_seq),
		.wr_ctl  (wr_ctl),
		.wr_addr (wr_addr),
		.wr_seq  (seq_next)
	);

	always_comb begin
		ex_status     = lfsm_pkg::STS_OK;
		ex_granted    = '0;
		ex_fseq       = '0;
		ex_dropped    = 1'b0;
		ex_commit     = 1'b0;
		ex_fail       = 1'b0;
		ex_clear      = 1'b0;
		wr_ctl.en     = 1'b0;
		wr_ctl.seq_en = 1'b0;
		wr_ctl.state  = lfsm_pkg::SLOT_FREE;
		wr_addr       = look_addr;
		if (!enable_q) begin
			ex_status = lfsm_pkg::STS_DISABLED;
		end else begin
			case (cmd_q)
				lfsm_pkg::CMD_ACQUIRE: begin
					if (lockout_q) begin
						ex_status = lfsm_pkg::STS_DISABLED;
					end else if (free_found_q) begin
						ex_granted   = free_idx_q;
						wr_addr      = free_idx_q;
						wr_ctl.en    = 1'b1;
						wr_ctl.state = lfsm_pkg::SLOT_INUSE;
					end else if (pick_found_q) begin
						ex_granted   = pick_idx_q;
						ex_dropped   = 1'b1;
						wr_addr      = pick_idx_q;
						wr_ctl.en    = 1'b1;
						wr_ctl.state = lfsm_pkg::SLOT_INUSE;
					end else begin
						ex_status = lfsm_pkg::STS_NO_SLOT;
					end
				end
				lfsm_pkg::CMD_COMMIT_OK, lfsm_pkg::CMD_COMMIT_FAIL: begin
					if (lockout_q) begin
						ex_status = lfsm_pkg::STS_DISABLED;
					end else if (!idx_ok || rd_state != lfsm_pkg::SLOT_INUSE) begin
						ex_status = lfsm_pkg::STS_WRONG;
					end else if (cmd_q == lfsm_pkg::CMD_COMMIT_OK) begin
						ex_commit     = 1'b1;
						ex_fseq       = seq_next;
						wr_ctl.en     = 1'b1;
						wr_ctl.seq_en = 1'b1;
						wr_ctl.state  = lfsm_pkg::SLOT_READY;
					end else begin
						ex_fail   = 1'b1;
						wr_ctl.en = 1'b1;
					end
				end
				lfsm_pkg::CMD_TAKE: begin
					if (pick_found_q) begin
						ex_granted   = pick_idx_q;
						ex_fseq      = pick_seq_q;
						wr_addr      = pick_idx_q;
						wr_ctl.en    = 1'b1;
						wr_ctl.state = lfsm_pkg::SLOT_INUSE;
					end else begin
						ex_status = lfsm_pkg::STS_NO_SLOT;
					end
				end
				lfsm_pkg::CMD_RELEASE: begin
					if (!idx_ok || rd_state != lfsm_pkg::SLOT_INUSE) begin
						ex_status = lfsm_pkg::STS_WRONG;
					end else begin
						wr_ctl.en = 1'b1;
					end
				end
				lfsm_pkg::CMD_CLEAR_STATS: begin
					ex_clear = 1'b1;
				end
				default: begin
					ex_status = lfsm_pkg::STS_WRONG;
				end
			endcase
		end
		wr_ctl.en = wr_ctl.en && exec_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			enable_q         <= 1'b0;
			fail_threshold_q <= lfsm_pkg::FAIL_THRESHOLD_RST;
			scan_q           <= '0;
			cmp_vld_s1       <= 1'b0;
			free_found_q     <= 1'b0;
			free_idx_q       <= '0;
			pick_found_q     <= 1'b0;
			pick_idx_q       <= '0;
			pick_seq_q       <= '0;
			seq_counter_q    <= '0;
			fail_count_q     <= '0;
			lockout_q        <= 1'b0;
			prod_period_q    <= '0;
			prod_total_q     <= '0;
			drop_period_q    <= '0;
			drop_total_q     <= '0;
			rsp_valid_q      <= 1'b0;
			status_q         <= lfsm_pkg::STS_OK;
			granted_q        <= '0;
			fseq_q           <= '0;
			dropped_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lfsm_pkg::REG_ENABLE:         enable_q <= cfg_data[0];
					lfsm_pkg::REG_FAIL_THRESHOLD: fail_threshold_q <= cfg_data;
					default: ;
				endcase
			end

			cmp_vld_s1 <= (state_q == ST_SCAN);
			if (cmp_vld_s1) begin
				if (rd_state == lfsm_pkg::SLOT_FREE && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= cmp_idx_s1;
				end
				if (rd_state == lfsm_pkg::SLOT_READY && (!pick_found_q || cmp_less)) begin
					pick_found_q <= 1'b1;
					pick_idx_q   <= cmp_idx_s1;
					pick_seq_q   <= rd_seq;
				end
			end

			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_accept) begin
						scan_q       <= '0;
						free_found_q <= 1'b0;
						pick_found_q <= 1'b0;
						case (command)
							lfsm_pkg::CMD_ACQUIRE, lfsm_pkg::CMD_TAKE:
								state_q <= ST_SCAN;
							lfsm_pkg::CMD_COMMIT_OK, lfsm_pkg::CMD_COMMIT_FAIL,
							lfsm_pkg::CMD_RELEASE:
								state_q <= ST_LOOK;
							default:
								state_q <= ST_EXEC;
						endcase
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EXEC;
				end
				ST_LOOK: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
						status_q    <= ex_status;
						granted_q   <= ex_granted;
						fseq_q      <= lfsm_pkg::CNT_W'(ex_fseq);
						dropped_q   <= ex_dropped;
						if (ex_dropped) begin
							drop_period_q <= drop_period_q + 1'b1;
							drop_total_q  <= drop_total_q + 1'b1;
						end
						if (ex_commit) begin
							seq_counter_q <= seq_next;
							fail_count_q  <= '0;
							prod_period_q <= prod_period_q + 1'b1;
							prod_total_q  <= prod_total_q + 1'b1;
						end
						if (ex_fail) begin
							fail_count_q <= fail_next;
							if (fail_next >= fail_threshold_q) begin
								lockout_q <= 1'b1;
							end
						end
						if (ex_clear) begin
							prod_period_q <= '0;
							drop_period_q <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// data phase of the scan (address issued in the previous cycle); also latches the accepted command
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q;
		if (cmd_accept) begin
			cmd_q        <= command;
			slot_index_q <= slot_index;
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign status            = status_q;
	assign granted_slot      = lfsm_pkg::IDX_W'(granted_q);
	assign frame_seq         = fseq_q;
	assign dropped_now       = dropped_q;
	assign locked_out        = lockout_q;
	assign produced_period   = prod_period_q;
	assign produced_lifetime = prod_total_q;
	assign dropped_period    = drop_period_q;
	assign dropped_lifetime  = drop_total_q;

	// lockout is sticky until reset
	a_lockout_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		lockout_q |=> lockout_q)
		else $error("lockout cleared without reset");

	// state only changes when the response register is free
	a_exec_holds_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> $stable(prod_total_q) && $stable(drop_total_q)
			&& $stable(lockout_q))
		else $error("counters moved under a stalled response");

	// produced total advances by at most one per command
	a_prod_step: assert property (@(posedge clk) disable iff (!arst_n)
		(prod_total_q != $past(prod_total_q)) |->
			(prod_total_q == $past(prod_total_q) + 1'b1) && $past(exec_go))
		else $error("produced total jumped");

	// a drop report always comes with a successful grant
	a_drop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && dropped_q) |-> (status_q == lfsm_pkg::STS_OK))
		else $error("drop flagged on a failed command");

	// a new response only follows the execute step
	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("response raised outside execute");

endmodule
`default_nettype wire

@@ sv/lfsm_slot_store.sv @@
// Slot state and sequence store: one registered read port, one write port.
`timescale 1ns / 1ps
`default_nettype none
module lfsm_slot_store #(
	parameter int SLOT_COUNT = lfsm_pkg::SLOT_COUNT_DEF,
	parameter int SEQ_BITS   = lfsm_pkg::SEQ_BITS_DEF,
	parameter int IW         = $clog2(SLOT_COUNT)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IW-1:0]         rd_addr,
	output lfsm_pkg::slot_state_t      rd_state,
	output logic      [SEQ_BITS-1:0]   rd_seq,
	input  wire lfsm_pkg::slot_wr_t    wr_ctl,
	input  wire logic [IW-1:0]         wr_addr,
	input  wire logic [SEQ_BITS-1:0]   wr_seq
);

	lfsm_pkg::slot_state_t state_q [SLOT_COUNT];
	logic [SEQ_BITS-1:0]   seq_q   [SLOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				state_q[i] <= lfsm_pkg::SLOT_FREE;
				seq_q[i]   <= '0;
			end
		end else if (wr_ctl.en) begin
			state_q[wr_addr] <= wr_ctl.state;
			if (wr_ctl.seq_en) begin
				seq_q[wr_addr] <= wr_seq;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_state <= state_q[rd_addr];
		rd_seq   <= seq_q[rd_addr];
	end

endmodule
`default_nettype wire
